// File: src/svr_pkg.sv
// ----------------------------------------------------------------------------
// svr_pkg: shared types, constants and functions of the stereo vocal remover
// Signal formats, lane control structs, saturation helpers and the
// elaboration-time coefficient design (biquads and first-order allpass).
// ----------------------------------------------------------------------------
package svr_pkg;

  localparam int SMP_W   = 16;   // audio sample width
  localparam int SIG_W   = 40;   // internal signal, 16 fraction bits
  localparam int EXT_W   = 41;   // signal difference before saturation
  localparam int COEF_W  = 34;   // coefficient / weight width
  localparam int ACC_W   = 64;   // MAC accumulator width
  localparam int LVL_W   = 16;   // suppression level register width
  localparam int LVL_FULL = 32768;

  localparam logic signed [ACC_W-1:0] SIG_MAX = (64'sd1 <<< (SIG_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SIG_MIN = -(64'sd1 <<< (SIG_W - 1));

  localparam longint Q30_ONE = 64'sd1 <<< 30;
  localparam longint PI_Q30  = 64'sd3373259426;

  typedef logic signed [SIG_W-1:0]  sig_t;
  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef coef_t [4:0]              bq_coef_t;  // b0 b1 b2 a1 a2
  typedef coef_t [2:0]              ap_coef_t;  // allpass sections of a chain

  // lane sequencer states
  typedef enum logic [3:0] {
    LN_IDLE,
    LN_BQ_ISSUE,
    LN_BQ_WAIT,
    LN_MID,
    LN_SIDE,
    LN_AP_ISSUE,
    LN_AP_WAIT,
    LN_BL_ISSUE,
    LN_BL_WAIT,
    LN_DONE
  } lane_state_e;

  // one request into the MAC pipeline
  typedef struct packed {
    logic  valid;
    logic  first;   // start a new sum
    logic  neg;     // subtract the product
    logic  blend;   // round at 30 bits instead of the coefficient scale
    ext_t  s;
    coef_t c;
  } mac_req_t;

  // top -> lane
  typedef struct packed {
    logic start;
    logic side_go;
    logic ack;
    sig_t side;
    smp_t sample;
  } lane_ctl_t;

  // lane -> top
  typedef struct packed {
    logic mid_valid;
    logic done;
    sig_t mid;
    smp_t sample_out;
  } lane_st_t;

  typedef struct packed {
    logic signed [63:0] sn;
    logic signed [63:0] cs;
  } sc_t;

  // saturate a wide sum to the 40-bit signal range
  function automatic sig_t sat40(input acc_t v);
    sig_t r;
    if (v > SIG_MAX) r = SIG_MAX[SIG_W-1:0];
    else if (v < SIG_MIN) r = SIG_MIN[SIG_W-1:0];
    else r = v[SIG_W-1:0];
    return r;
  endfunction

  // truncate toward zero to an integer, then saturate to 16 bits
  function automatic smp_t to_out16(input sig_t v);
    ext_t t;
    logic signed [EXT_W-17:0] q;
    smp_t r;
    t = EXT_W'(v) + ((v < 0) ? ext_t'(65535) : ext_t'(0));
    q = t[EXT_W-1:16];
    if (q > 32767) r = smp_t'(32767);
    else if (q < -32768) r = smp_t'(-32768);
    else r = q[SMP_W-1:0];
    return r;
  endfunction

  // ---- elaboration-time coefficient design ----

  // restoring division, used only on constants
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round half up of s*c / 2^n
  function automatic longint mul_round(input longint s, input longint c, input int n);
    return (s * c + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // num/den in Q30, rounded half away from zero
  function automatic longint div_q30(input longint num, input longint den);
    longint          d;
    longint unsigned mag;
    longint unsigned q;
    d   = (den <= 0) ? 64'sd1 : den;
    mag = (num < 0) ? -num : num;
    q   = udiv((mag << 30) + (d >> 1), d);
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic sc_t sin_cos_q30(input longint xin);
    longint x;
    longint x2;
    longint ts;
    longint tc;
    longint ss;
    longint cc;
    longint ds;
    longint dc;
    logic   flip;
    sc_t    r;
    x = xin;
    flip = 1'b0;
    if (x < 0) x = 0;
    if (x > PI_Q30) x = PI_Q30;
    if (2 * x > PI_Q30) begin
      x = PI_Q30 - x;
      flip = 1'b1;
    end
    x2 = mul_round(x, x, 30);
    ts = x;
    ss = x;
    tc = Q30_ONE;
    cc = Q30_ONE;
    for (int k = 1; k <= 10; k++) begin
      ds = longint'(2 * k) * longint'(2 * k + 1);
      dc = longint'(2 * k - 1) * longint'(2 * k);
      ts = $signed(udiv(mul_round(ts, x2, 30) + (ds >> 1), ds));
      tc = $signed(udiv(mul_round(tc, x2, 30) + (dc >> 1), dc));
      if (k % 2 == 1) begin
        ss = ss - ts;
        cc = cc - tc;
      end else begin
        ss = ss + ts;
        cc = cc + tc;
      end
    end
    r.sn = ss;
    r.cs = flip ? -cc : cc;
    return r;
  endfunction

  function automatic longint to_coef(input longint q30, input int cf);
    if (cf >= 30) return q30;
    return mul_round(q30, 1, 30 - cf);
  endfunction

  function automatic longint angle_q30(input longint pm, input longint hz, input longint sr);
    return $signed(udiv(pm * PI_Q30 * hz + (sr >> 1), sr));
  endfunction

  function automatic bq_coef_t design_biquad(input longint hz, input logic high,
                                             input longint sr, input int cf);
    sc_t      sc;
    longint   inv2q;
    longint   al;
    longint   a0;
    longint   nn;
    longint   q [5];
    bq_coef_t c;
    inv2q = $signed(udiv((64'd100000000 << 30) + 64'd70710678, 64'd141421356));
    sc = sin_cos_q30(angle_q30(2, hz, sr));
    al = mul_round(sc.sn, inv2q, 30);
    a0 = Q30_ONE + al;
    nn = high ? (Q30_ONE + sc.cs) : (Q30_ONE - sc.cs);
    q[0] = div_q30(nn, 2 * a0);
    q[1] = high ? -div_q30(nn, a0) : div_q30(nn, a0);
    q[2] = q[0];
    q[3] = div_q30(-2 * sc.cs, a0);
    q[4] = div_q30(Q30_ONE - al, a0);
    for (int i = 0; i < 5; i++) c[i] = COEF_W'(to_coef(q[i], cf));
    return c;
  endfunction

  function automatic coef_t design_allpass(input longint hz, input longint sr, input int cf);
    sc_t    sc;
    longint t;
    sc = sin_cos_q30(angle_q30(1, hz, sr));
    t  = div_q30(sc.sn, sc.cs);
    return COEF_W'(to_coef(div_q30(t - Q30_ONE, t + Q30_ONE), cf));
  endfunction

  // chain of up to three sections; a zero frequency leaves the slot empty
  function automatic ap_coef_t ap_set(input longint f0, input longint f1, input longint f2,
                                      input longint sr, input int cf);
    ap_coef_t c;
    c[0] = (f0 != 0) ? design_allpass(f0, sr, cf) : '0;
    c[1] = (f1 != 0) ? design_allpass(f1, sr, cf) : '0;
    c[2] = (f2 != 0) ? design_allpass(f2, sr, cf) : '0;
    return c;
  endfunction

endpackage

// File: src/svr_in_if.sv
// ----------------------------------------------------------------------------
// svr_in_if: input stream of stereo frames
// valid/ready handshake carrying one left/right sample pair per word.
// ----------------------------------------------------------------------------
interface svr_in_if
  import svr_pkg::*;
();
  logic valid;
  logic ready;
  smp_t left_sample;
  smp_t right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// File: src/svr_out_if.sv
// ----------------------------------------------------------------------------
// svr_out_if: output stream of processed stereo frames
// valid/ready handshake carrying one left/right sample pair per word.
// ----------------------------------------------------------------------------
interface svr_out_if
  import svr_pkg::*;
();
  logic valid;
  logic ready;
  smp_t left_out;
  smp_t right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// File: src/stereo_vocal_remover_core.sv
// ----------------------------------------------------------------------------
// stereo_vocal_remover_core: band-split allpass vocal remover
// Two channel lanes, a merge stage for the side signal, output register.
// ----------------------------------------------------------------------------
// Each channel lane owns one three-stage MAC pipeline and runs on it, in
// order, four biquads (five products each, then a drain of the pipeline),
// its allpass sections (the left chain being the longest at three) and the
// two-product blend. A new frame is taken once the previous one sits in the
// output register, so the output may stall while the next frame runs.
// Coefficients are fixed at elaboration from SAMPLE_RATE; the suppression
// level is written through cfg_we_i/cfg_wdata_i, which the user must do only
// while idle (the block itself does not enforce it); values above 32768 act
// as full removal.
module stereo_vocal_remover_core
  import svr_pkg::*;
#(
  parameter int SAMPLE_RATE    = 48000,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  svr_in_if.sink             in_i,
  svr_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [LVL_W-1:0]   cfg_wdata_i
);

  localparam bq_coef_t LP_C = design_biquad(130, 1'b0, SAMPLE_RATE, COEF_FRAC_BITS);
  localparam bq_coef_t HP_C = design_biquad(10500, 1'b1, SAMPLE_RATE, COEF_FRAC_BITS);
  localparam ap_coef_t AP_L = ap_set(150, 1250, 9800, SAMPLE_RATE, COEF_FRAC_BITS);
  localparam ap_coef_t AP_R = ap_set(430, 3500, 0, SAMPLE_RATE, COEF_FRAC_BITS);

  coef_t wdry_q, wwet_q;
  logic  busy_q, out_valid_q;
  smp_t  left_q, right_q;

  lane_ctl_t ctl_l, ctl_r;
  lane_st_t  st_l, st_r;
  logic      in_acc, load_out, side_go;
  logic [LVL_W-1:0] lvl;
  ext_t      diff;

  // level weights, updated on a config write
  assign lvl = (cfg_wdata_i > LVL_W'(LVL_FULL)) ? LVL_W'(LVL_FULL) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdry_q <= '0;
      wwet_q <= coef_t'(64'sd2147483648);
    end else if (cfg_we_i) begin
      wdry_q <= COEF_W'({(17'(LVL_FULL) - 17'(lvl)), 15'b0});
      wwet_q <= COEF_W'(34'(17'(LVL_FULL) + 17'(lvl)) * 34'(lvl));
    end
  end

  // merge stage: side = floor((midL - midR) / 2)
  always_comb begin
    in_acc   = in_i.valid && in_i.ready;
    side_go  = st_l.mid_valid && st_r.mid_valid;
    load_out = st_l.done && st_r.done && (!out_valid_q || out_o.ready);
    diff     = EXT_W'(st_l.mid) - EXT_W'(st_r.mid);

    ctl_l.start   = in_acc;
    ctl_l.side_go = side_go;
    ctl_l.ack     = load_out;
    ctl_l.side    = diff[EXT_W-1:1];
    ctl_l.sample  = in_i.left_sample;
    ctl_r         = ctl_l;
    ctl_r.sample  = in_i.right_sample;
  end

  svr_lane #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NUM_AP         (3),
    .LP_C           (LP_C),
    .HP_C           (HP_C),
    .AP_C           (AP_L)
  ) u_lane_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_l),
    .wdry_i (wdry_q),
    .wwet_i (wwet_q),
    .st_o   (st_l)
  );

  svr_lane #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NUM_AP         (2),
    .LP_C           (LP_C),
    .HP_C           (HP_C),
    .AP_C           (AP_R)
  ) u_lane_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_r),
    .wdry_i (wdry_q),
    .wwet_i (wwet_q),
    .st_o   (st_r)
  );

  // frame tracking and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) busy_q <= 1'b1;
      else if (load_out) busy_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      left_q  <= st_l.sample_out;
      right_q <= st_r.sample_out;
    end
  end

  assign in_i.ready      = !busy_q;
  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = left_q;
  assign out_o.right_out = right_q;

`ifndef SYNTHESIS
  a_fall_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(load_out))
    else $error("frame ended without loading the output word");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && !st_l.done && !st_r.done)
    else $error("accepted word did not start the lanes");

  a_idle_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !st_l.done && !st_r.done && !st_l.mid_valid && !st_r.mid_valid)
    else $error("lane active while no frame is in flight");
`endif

endmodule

// File: src/svr_mac.sv
// ----------------------------------------------------------------------------
// svr_mac: pipelined multiply-accumulate unit
// 41-bit signal times 34-bit coefficient as two partial products, rounded
// half up, then added to or subtracted from the accumulator. Three stages.
// ----------------------------------------------------------------------------
module svr_mac
  import svr_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output acc_t     acc_o,
  output logic     busy_o
);

  localparam int LO_W   = 21;
  localparam int HI_W   = EXT_W - LO_W;
  localparam int PL_W   = COEF_W + LO_W + 1;
  localparam int PH_W   = COEF_W + HI_W;
  localparam int FULL_W = COEF_W + EXT_W;

  logic v1_q, v2_q;
  logic first1_q, neg1_q, blend1_q;
  logic first2_q, neg2_q;
  logic signed [PL_W-1:0] pl_q;
  logic signed [PH_W-1:0] ph_q;
  logic signed [FULL_W-1:0] full, rnd_b, rnd_c;
  acc_t r_q, r_d, acc_q;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  // stage 2: join partials and round
  always_comb begin
    full  = (FULL_W'(ph_q) <<< LO_W) + FULL_W'(pl_q);
    rnd_b = (full + (FULL_W'(1) <<< 29)) >>> 30;
    rnd_c = (full + (FULL_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    r_d   = blend1_q ? rnd_b[ACC_W-1:0] : rnd_c[ACC_W-1:0];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pl_q     <= req_i.c * $signed({1'b0, req_i.s[LO_W-1:0]});
    ph_q     <= req_i.c * $signed(req_i.s[EXT_W-1:LO_W]);
    first1_q <= req_i.first;
    neg1_q   <= req_i.neg;
    blend1_q <= req_i.blend;
    r_q      <= r_d;
    first2_q <= first1_q;
    neg2_q   <= neg1_q;
    if (v2_q) begin
      acc_q <= (first2_q ? acc_t'(0) : acc_q) + (neg2_q ? -r_q : r_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | v2_q;

endmodule

// File: src/svr_lane.sv
// ----------------------------------------------------------------------------
// svr_lane: one channel of the vocal remover
// Runs the four band-split biquads, hands its mid band to the merge stage,
// then runs its allpass chain on the side signal and blends the result.
// ----------------------------------------------------------------------------
module svr_lane
  import svr_pkg::*;
#(
  parameter int       COEF_FRAC_BITS = 30,
  parameter int       NUM_AP         = 3,
  parameter bq_coef_t LP_C           = '0,
  parameter bq_coef_t HP_C           = '0,
  parameter ap_coef_t AP_C           = '0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  coef_t     wdry_i,
  input  coef_t     wwet_i,
  output lane_st_t  st_o
);

  localparam int AP_IW = (NUM_AP > 1) ? $clog2(NUM_AP) : 1;

  lane_state_e state_q, state_d;
  logic [1:0]       bq_idx_q;   // LP1, LP2, HP1, HP2
  logic [2:0]       op_q;
  logic [AP_IW-1:0] ap_idx_q;
  logic             ap_last;

  sig_t bq_h_q [4][4];          // x1, x2, y1, y2 per biquad
  sig_t ap_x1_q [NUM_AP];
  sig_t ap_y1_q [NUM_AP];
  sig_t stage_y_q [4];
  sig_t x_q, mid_q, ap_x_q;
  smp_t out_q;

  mac_req_t req;
  acc_t     acc;
  logic     busy;
  sig_t     bq_in, bq_y, ap_y, fsum;
  bq_coef_t bq_c;

  svr_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .acc_o  (acc),
    .busy_o (busy)
  );

  // results of the current operation
  always_comb begin
    bq_in   = bq_idx_q[0] ? stage_y_q[{bq_idx_q[1], 1'b0}] : x_q;
    bq_c    = bq_idx_q[1] ? HP_C : LP_C;
    bq_y    = sat40(acc);
    ap_y    = sat40(acc + ACC_W'(ap_x1_q[ap_idx_q]));
    fsum    = sat40(ACC_W'(stage_y_q[1]) + ACC_W'(sat40(acc)) + ACC_W'(stage_y_q[3]));
    ap_last = (ap_idx_q == AP_IW'(NUM_AP - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LN_IDLE:     if (ctl_i.start) state_d = LN_BQ_ISSUE;
      LN_BQ_ISSUE: if (op_q == 3'd4) state_d = LN_BQ_WAIT;
      LN_BQ_WAIT: begin
        if (!busy) state_d = (bq_idx_q == 2'd3) ? LN_MID : LN_BQ_ISSUE;
      end
      LN_MID:      state_d = LN_SIDE;
      LN_SIDE:     if (ctl_i.side_go) state_d = LN_AP_ISSUE;
      LN_AP_ISSUE: state_d = LN_AP_WAIT;
      LN_AP_WAIT: begin
        if (!busy) state_d = ap_last ? LN_BL_ISSUE : LN_AP_ISSUE;
      end
      LN_BL_ISSUE: if (op_q == 3'd1) state_d = LN_BL_WAIT;
      LN_BL_WAIT:  if (!busy) state_d = LN_DONE;
      LN_DONE:     if (ctl_i.ack) state_d = LN_IDLE;
      default:     state_d = LN_IDLE;
    endcase
  end

  // MAC requests and status
  always_comb begin
    req = '0;
    unique case (state_q)
      LN_BQ_ISSUE: begin
        req.valid = 1'b1;
        req.first = (op_q == 3'd0);
        req.neg   = (op_q >= 3'd3);
        unique case (op_q)
          3'd0:    req.s = EXT_W'(bq_in);
          3'd1:    req.s = EXT_W'(bq_h_q[bq_idx_q][0]);
          3'd2:    req.s = EXT_W'(bq_h_q[bq_idx_q][1]);
          3'd3:    req.s = EXT_W'(bq_h_q[bq_idx_q][2]);
          3'd4:    req.s = EXT_W'(bq_h_q[bq_idx_q][3]);
          default: req.s = '0;
        endcase
        unique case (op_q)
          3'd0:    req.c = bq_c[0];
          3'd1:    req.c = bq_c[1];
          3'd2:    req.c = bq_c[2];
          3'd3:    req.c = bq_c[3];
          3'd4:    req.c = bq_c[4];
          default: req.c = '0;
        endcase
      end
      LN_AP_ISSUE: begin
        req.valid = 1'b1;
        req.first = 1'b1;
        req.s     = EXT_W'(ap_x_q) - EXT_W'(ap_y1_q[ap_idx_q]);
        req.c     = AP_C[ap_idx_q];
      end
      LN_BL_ISSUE: begin
        req.valid = 1'b1;
        req.blend = 1'b1;
        req.first = (op_q == 3'd0);
        req.s     = (op_q == 3'd0) ? EXT_W'(mid_q) : EXT_W'(ap_x_q);
        req.c     = (op_q == 3'd0) ? wdry_i : wwet_i;
      end
      default: req = '0;
    endcase
    st_o.mid_valid  = (state_q == LN_SIDE);
    st_o.done       = (state_q == LN_DONE);
    st_o.mid        = mid_q;
    st_o.sample_out = out_q;
  end

  // control and filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LN_IDLE;
      bq_idx_q <= '0;
      op_q     <= '0;
      ap_idx_q <= '0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) bq_h_q[i][j] <= '0;
      end
      for (int i = 0; i < NUM_AP; i++) begin
        ap_x1_q[i] <= '0;
        ap_y1_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        LN_IDLE: begin
          bq_idx_q <= '0;
          op_q     <= '0;
        end
        LN_BQ_ISSUE: op_q <= (op_q == 3'd4) ? 3'd0 : op_q + 3'd1;
        LN_BQ_WAIT: begin
          if (!busy) begin
            bq_h_q[bq_idx_q][1] <= bq_h_q[bq_idx_q][0];
            bq_h_q[bq_idx_q][0] <= bq_in;
            bq_h_q[bq_idx_q][3] <= bq_h_q[bq_idx_q][2];
            bq_h_q[bq_idx_q][2] <= bq_y;
            bq_idx_q <= bq_idx_q + 2'd1;
          end
        end
        LN_SIDE: ap_idx_q <= '0;
        LN_AP_WAIT: begin
          if (!busy) begin
            ap_x1_q[ap_idx_q] <= ap_x_q;
            ap_y1_q[ap_idx_q] <= ap_y;
            op_q <= '0;
            if (!ap_last) ap_idx_q <= ap_idx_q + AP_IW'(1);
          end
        end
        LN_BL_ISSUE: op_q <= op_q + 3'd1;
        default: ;
      endcase
    end
  end

  // per-frame data
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LN_IDLE: if (ctl_i.start) x_q <= SIG_W'(ctl_i.sample) <<< 16;
      LN_BQ_WAIT: if (!busy) stage_y_q[bq_idx_q] <= bq_y;
      LN_MID: mid_q <= sat40(ACC_W'(x_q) - ACC_W'(stage_y_q[1]) - ACC_W'(stage_y_q[3]));
      LN_SIDE: if (ctl_i.side_go) ap_x_q <= ctl_i.side;
      LN_AP_WAIT: if (!busy) ap_x_q <= ap_y;
      LN_BL_WAIT: if (!busy) out_q <= to_out16(fsum);
      default: ;
    endcase
  end

endmodule
